@@ design/bpec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ball pair elastic collision pipeline.
// No dependencies; imported by every module of the block.
package bpec_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DIAM_W    = 31;
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 2 * MAG_W + 1;
  localparam int ROOT_W    = 32;
  localparam int RAD_W     = 64;
  localparam int SQRT_STAGES = 32;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int REM_W     = ROOT_W + QUO_W;
  localparam int UNIT_W    = QUO_W + 1;
  localparam int H_W       = DIAM_W - 1;
  localparam int DV_W      = DW + 1;
  localparam int MD_W      = DV_W + UNIT_W;
  localparam int MS_W      = UNIT_W + H_W + 1;
  localparam int P_W       = MD_W + 1 - FRAC_BITS;
  localparam int PD_W      = UNIT_W + P_W;

  typedef struct packed {
    logic signed [DW-1:0] p1x;
    logic signed [DW-1:0] p1y;
    logic signed [DW-1:0] v1x;
    logic signed [DW-1:0] v1y;
    logic signed [DW-1:0] p2x;
    logic signed [DW-1:0] p2y;
    logic signed [DW-1:0] v2x;
    logic signed [DW-1:0] v2y;
  } pair_t;

  typedef struct packed {
    pair_t            pair;
    logic             near;
    logic             hit;
    logic             sgn_x;
    logic             sgn_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } sqrt_side_t;

  typedef struct packed {
    pair_t          pair;
    logic           hit;
    logic           push;
    logic           sgn_x;
    logic           sgn_y;
    logic [H_W-1:0] h;
  } div_side_t;

  typedef struct packed {
    pair_t pair;
    logic  hit;
  } result_t;

endpackage

@@ design/bpec_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on bpec_pkg; carries the sqrt_side_t payload alongside.
module bpec_sqrt import bpec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SQ_W-1:0]  radicand_i,
  input  sqrt_side_t       side_i,
  output logic             valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sqrt_side_t       side_o
);

  logic [SQRT_STAGES-1:0] vld_q;
  logic [RAD_W-1:0]       rem_q  [SQRT_STAGES];
  logic [RAD_W-1:0]       res_q  [SQRT_STAGES];
  sqrt_side_t             side_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [RAD_W-1:0] StepBit = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [RAD_W-1:0] rem_in, res_in, trial, rem_d, res_d;
    logic             v_in;
    sqrt_side_t       side_in;

    if (k == 0) begin : g_first
      assign rem_in  = RAD_W'(radicand_i);
      assign res_in  = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign v_in    = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial = res_in + StepBit;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + StepBit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign root_o  = res_q[SQRT_STAGES-1][ROOT_W-1:0];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

@@ design/bpec_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two numerators over one shared divisor.
// Depends on bpec_pkg; one quotient bit per stage, carries div_side_t.
module bpec_div import bpec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_x_i,
  input  logic [NUM_W-1:0]  num_y_i,
  input  logic [ROOT_W-1:0] den_i,
  input  div_side_t         side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_x_o,
  output logic [QUO_W-1:0]  quo_y_o,
  output div_side_t         side_o
);

  logic [QUO_W-1:0]  vld_q;
  logic [REM_W-1:0]  rx_q   [QUO_W];
  logic [REM_W-1:0]  ry_q   [QUO_W];
  logic [QUO_W-1:0]  qx_q   [QUO_W];
  logic [QUO_W-1:0]  qy_q   [QUO_W];
  logic [ROOT_W-1:0] den_q  [QUO_W];
  div_side_t         side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int Sh = QUO_W - 1 - k;
    logic [REM_W-1:0]  rx_in, ry_in, dsh, rx_d, ry_d;
    logic [QUO_W-1:0]  qx_in, qy_in, qx_d, qy_d;
    logic [ROOT_W-1:0] den_in;
    logic              v_in;
    div_side_t         side_in;

    if (k == 0) begin : g_first
      assign rx_in   = REM_W'(num_x_i);
      assign ry_in   = REM_W'(num_y_i);
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign den_in  = den_q[k-1];
      assign v_in    = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      dsh  = REM_W'(den_in) << Sh;
      rx_d = rx_in;
      ry_d = ry_in;
      qx_d = qx_in;
      qy_d = qy_in;
      if (rx_in >= dsh) begin
        rx_d = rx_in - dsh;
        qx_d = qx_in | (QUO_W'(1) << Sh);
      end
      if (ry_in >= dsh) begin
        ry_d = ry_in - dsh;
        qy_d = qy_in | (QUO_W'(1) << Sh);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= rx_d;
        ry_q[k]   <= ry_d;
        qx_q[k]   <= qx_d;
        qy_q[k]   <= qy_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_x_o = qx_q[QUO_W-1];
  assign quo_y_o = qy_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

@@ design/ball_pair_elastic_collision.sv @@
`timescale 1ns / 1ps
// Top level: elastic collision of two equal discs, fully pipelined.
// Depends on bpec_pkg, bpec_sqrt and bpec_div.
//
//   channel | handshake                    | transfer
//   in      | in_valid_i / in_ready_o      | two discs: positions, velocities
//   out     | out_valid_o / out_ready_i    | updated discs and collided flag
//   cfg     | APB psel/penable/pwrite      | diameter at byte address 0
//
// One pair enters per cycle while in_ready_o is high; the path runs through the 32-stage square
// root and the 17-stage unit-vector divider plus 9 arithmetic stages and the
// output buffer.
// The pipeline advances as a whole while the 2-entry output buffer has room,
// so in_ready_o depends only on registered state.
// Reset clears all valid bits and sets the diameter to 1.0; no clearing pass.
module ball_pair_elastic_collision import bpec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DW-1:0] first_pos_x_i,
  input  logic signed [DW-1:0] first_pos_y_i,
  input  logic signed [DW-1:0] first_vel_x_i,
  input  logic signed [DW-1:0] first_vel_y_i,
  input  logic signed [DW-1:0] second_pos_x_i,
  input  logic signed [DW-1:0] second_pos_y_i,
  input  logic signed [DW-1:0] second_vel_x_i,
  input  logic signed [DW-1:0] second_vel_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] new_first_pos_x_o,
  output logic signed [DW-1:0] new_first_pos_y_o,
  output logic signed [DW-1:0] new_first_vel_x_o,
  output logic signed [DW-1:0] new_first_vel_y_o,
  output logic signed [DW-1:0] new_second_pos_x_o,
  output logic signed [DW-1:0] new_second_pos_y_o,
  output logic signed [DW-1:0] new_second_vel_x_o,
  output logic signed [DW-1:0] new_second_vel_y_o,
  output logic                 collided_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [1:0] OutDepth = 2'd2;
  localparam logic [DIAM_W-1:0] DiamReset = DIAM_W'(1) << FRAC_BITS;

  // configuration
  logic [DIAM_W-1:0]   diameter_q;
  logic [2*DIAM_W-1:0] dsq_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(diameter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diameter_q <= DiamReset;
    end else if (cfg_wr) begin
      diameter_q <= pwdata[DIAM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dsq_q <= diameter_q * diameter_q;
  end

  // flow control
  logic [1:0] cnt_q, cnt_d;
  logic       en, push, pop;

  assign en         = (cnt_q != OutDepth);
  assign in_ready_o = en;

  // stage 1: offsets
  logic                s1_vld_q;
  pair_t               s1_pair_q;
  logic signed [DW:0]  s1_dx_q, s1_dy_q;
  pair_t               in_pair;

  assign in_pair = '{p1x: first_pos_x_i, p1y: first_pos_y_i,
                     v1x: first_vel_x_i, v1y: first_vel_y_i,
                     p2x: second_pos_x_i, p2y: second_pos_y_i,
                     v2x: second_vel_x_i, v2y: second_vel_y_i};

  // stage 2: magnitudes and range test
  logic               s2_vld_q;
  pair_t              s2_pair_q;
  logic               s2_near_q, s2_sx_q, s2_sy_q;
  logic [MAG_W-1:0]   s2_mx_q, s2_my_q;
  logic [DW:0]        mag_x, mag_y;

  assign mag_x = s1_dx_q[DW] ? DV_W'(-s1_dx_q) : DV_W'(s1_dx_q);
  assign mag_y = s1_dy_q[DW] ? DV_W'(-s1_dy_q) : DV_W'(s1_dy_q);

  // stage 3: squares
  logic               s3_vld_q;
  sqrt_side_t         s3_side_q;
  logic [2*MAG_W-1:0] s3_sqx_q, s3_sqy_q;

  // stage 4: squared distance and overlap test
  logic               s4_vld_q;
  sqrt_side_t         s4_side_q;
  logic [SQ_W-1:0]    s4_d2_q;
  logic [SQ_W-1:0]    dist2;

  assign dist2 = {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pair_q <= in_pair;
      s1_dx_q   <= {second_pos_x_i[DW-1], second_pos_x_i}
                 - {first_pos_x_i[DW-1], first_pos_x_i};
      s1_dy_q   <= {second_pos_y_i[DW-1], second_pos_y_i}
                 - {first_pos_y_i[DW-1], first_pos_y_i};

      s2_pair_q <= s1_pair_q;
      s2_near_q <= (mag_x <= DV_W'(diameter_q)) && (mag_y <= DV_W'(diameter_q))
                && ((s1_dx_q != '0) || (s1_dy_q != '0));
      s2_sx_q   <= s1_dx_q[DW];
      s2_sy_q   <= s1_dy_q[DW];
      s2_mx_q   <= mag_x[MAG_W-1:0];
      s2_my_q   <= mag_y[MAG_W-1:0];

      s3_side_q <= '{pair: s2_pair_q, near: s2_near_q, hit: 1'b0,
                     sgn_x: s2_sx_q, sgn_y: s2_sy_q, mag_x: s2_mx_q, mag_y: s2_my_q};
      s3_sqx_q  <= s2_mx_q * s2_mx_q;
      s3_sqy_q  <= s2_my_q * s2_my_q;

      s4_side_q <= '{pair: s3_side_q.pair, near: s3_side_q.near,
                     hit: s3_side_q.near && (dist2 < SQ_W'(dsq_q)),
                     sgn_x: s3_side_q.sgn_x, sgn_y: s3_side_q.sgn_y,
                     mag_x: s3_side_q.mag_x, mag_y: s3_side_q.mag_y};
      s4_d2_q   <= dist2;
    end
  end

  // square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side;

  bpec_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s4_vld_q),
    .radicand_i (s4_d2_q),
    .side_i     (s4_side_q),
    .valid_o    (sq_vld),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // stage 5: push amount
  logic              s5_vld_q;
  logic [ROOT_W-1:0] s5_dist_q;
  logic [NUM_W-1:0]  s5_nx_q, s5_ny_q;
  div_side_t         s5_side_q;
  logic [ROOT_W-1:0] gap;

  assign gap = ROOT_W'(diameter_q) - sq_root;

  // unit vector
  logic              dv_vld;
  logic [QUO_W-1:0]  qx, qy;
  div_side_t         dv_side;

  bpec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .num_x_i (s5_nx_q),
    .num_y_i (s5_ny_q),
    .den_i   (s5_dist_q),
    .side_i  (s5_side_q),
    .valid_o (dv_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (dv_side)
  );

  // stage 6: signed unit vector and velocity difference
  logic                     s6_vld_q;
  div_side_t                s6_side_q;
  logic signed [UNIT_W-1:0] s6_ux_q, s6_uy_q;
  logic signed [DV_W-1:0]   s6_dvx_q, s6_dvy_q;
  logic signed [UNIT_W-1:0] ux_abs, uy_abs;

  assign ux_abs = $signed({1'b0, qx});
  assign uy_abs = $signed({1'b0, qy});

  // stage 7: products with the unit vector
  logic                     s7_vld_q;
  div_side_t                s7_side_q;
  logic signed [UNIT_W-1:0] s7_ux_q, s7_uy_q;
  logic signed [MD_W-1:0]   s7_mdx_q, s7_mdy_q;
  logic signed [MS_W-1:0]   s7_msx_q, s7_msy_q;
  logic signed [H_W:0]      h_s;

  assign h_s = $signed({1'b0, s6_side_q.h});

  // stage 8: projection and push offsets
  logic                     s8_vld_q;
  div_side_t                s8_side_q;
  logic signed [UNIT_W-1:0] s8_ux_q, s8_uy_q;
  logic signed [P_W-1:0]    s8_p_q;
  logic [DW-1:0]            s8_sx_q, s8_sy_q;
  logic signed [MD_W:0]     dot;

  assign dot = {s7_mdx_q[MD_W-1], s7_mdx_q} + {s7_mdy_q[MD_W-1], s7_mdy_q};

  // stage 9: velocity exchange products
  logic                     s9_vld_q;
  div_side_t                s9_side_q;
  logic [DW-1:0]            s9_sx_q, s9_sy_q;
  logic signed [PD_W-1:0]   s9_pdx_q, s9_pdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= sq_vld;
      s6_vld_q <= dv_vld;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_dist_q <= sq_root;
      s5_nx_q   <= {sq_side.mag_x, {FRAC_BITS{1'b0}}};
      s5_ny_q   <= {sq_side.mag_y, {FRAC_BITS{1'b0}}};
      s5_side_q <= '{pair: sq_side.pair, hit: sq_side.hit,
                     push: sq_side.near && (sq_root <= ROOT_W'(diameter_q)),
                     sgn_x: sq_side.sgn_x, sgn_y: sq_side.sgn_y,
                     h: gap[DIAM_W-1:1]};

      s6_side_q <= dv_side;
      s6_ux_q   <= dv_side.sgn_x ? -ux_abs : ux_abs;
      s6_uy_q   <= dv_side.sgn_y ? -uy_abs : uy_abs;
      s6_dvx_q  <= {dv_side.pair.v2x[DW-1], dv_side.pair.v2x}
                 - {dv_side.pair.v1x[DW-1], dv_side.pair.v1x};
      s6_dvy_q  <= {dv_side.pair.v2y[DW-1], dv_side.pair.v2y}
                 - {dv_side.pair.v1y[DW-1], dv_side.pair.v1y};

      s7_side_q <= s6_side_q;
      s7_ux_q   <= s6_ux_q;
      s7_uy_q   <= s6_uy_q;
      s7_mdx_q  <= s6_dvx_q * s6_ux_q;
      s7_mdy_q  <= s6_dvy_q * s6_uy_q;
      s7_msx_q  <= s6_ux_q * h_s;
      s7_msy_q  <= s6_uy_q * h_s;

      s8_side_q <= s7_side_q;
      s8_ux_q   <= s7_ux_q;
      s8_uy_q   <= s7_uy_q;
      s8_p_q    <= dot[MD_W:FRAC_BITS];
      s8_sx_q   <= s7_msx_q[FRAC_BITS+DW-1:FRAC_BITS];
      s8_sy_q   <= s7_msy_q[FRAC_BITS+DW-1:FRAC_BITS];

      s9_side_q <= s8_side_q;
      s9_sx_q   <= s8_sx_q;
      s9_sy_q   <= s8_sy_q;
      s9_pdx_q  <= s8_ux_q * s8_p_q;
      s9_pdy_q  <= s8_uy_q * s8_p_q;
    end
  end

  // final update
  result_t       res;
  logic [DW-1:0] ddx, ddy, shx, shy;

  always_comb begin
    ddx = s9_side_q.hit ? s9_pdx_q[FRAC_BITS+DW-1:FRAC_BITS] : '0;
    ddy = s9_side_q.hit ? s9_pdy_q[FRAC_BITS+DW-1:FRAC_BITS] : '0;
    shx = s9_side_q.push ? s9_sx_q : '0;
    shy = s9_side_q.push ? s9_sy_q : '0;
    res.hit      = s9_side_q.hit;
    res.pair.p1x = s9_side_q.pair.p1x - shx;
    res.pair.p1y = s9_side_q.pair.p1y - shy;
    res.pair.p2x = s9_side_q.pair.p2x + shx;
    res.pair.p2y = s9_side_q.pair.p2y + shy;
    res.pair.v1x = s9_side_q.pair.v1x + ddx;
    res.pair.v1y = s9_side_q.pair.v1y + ddy;
    res.pair.v2x = s9_side_q.pair.v2x - ddx;
    res.pair.v2y = s9_side_q.pair.v2y - ddy;
  end

  // output buffer
  result_t mem_q [OutDepth];
  logic    wr_ptr_q, rd_ptr_q;
  result_t head;

  assign push = en && s9_vld_q;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  assign head               = mem_q[rd_ptr_q];
  assign out_valid_o        = (cnt_q != 2'd0);
  assign new_first_pos_x_o  = head.pair.p1x;
  assign new_first_pos_y_o  = head.pair.p1y;
  assign new_first_vel_x_o  = head.pair.v1x;
  assign new_first_vel_y_o  = head.pair.v1y;
  assign new_second_pos_x_o = head.pair.p2x;
  assign new_second_pos_y_o = head.pair.p2y;
  assign new_second_vel_x_o = head.pair.v2x;
  assign new_second_vel_y_o = head.pair.v2y;
  assign collided_o         = head.hit;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o) else $error("stall without pending result");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o) else $error("written result not presented");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ball_pair_elastic_collision: random and directed disc pairs,
// predicted in Q16.16 and compared as whole results. Depends on bpec_pkg and the design.
module tb_top;
  import bpec_pkg::*;

  localparam logic [2:0] DIAM_ADDR  = 3'd0;
  localparam int         DRAIN_WAIT = 70;
  localparam int         STALL_LIM  = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pair_t pair_drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  result_t got;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ball_pair_elastic_collision DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_pos_x_i(pair_drv.p1x), .first_pos_y_i(pair_drv.p1y),
    .first_vel_x_i(pair_drv.v1x), .first_vel_y_i(pair_drv.v1y),
    .second_pos_x_i(pair_drv.p2x), .second_pos_y_i(pair_drv.p2y),
    .second_vel_x_i(pair_drv.v2x), .second_vel_y_i(pair_drv.v2y),
    .out_valid_o, .out_ready_i,
    .new_first_pos_x_o(got.pair.p1x), .new_first_pos_y_o(got.pair.p1y),
    .new_first_vel_x_o(got.pair.v1x), .new_first_vel_y_o(got.pair.v1y),
    .new_second_pos_x_o(got.pair.p2x), .new_second_pos_y_o(got.pair.p2y),
    .new_second_vel_x_o(got.pair.v2x), .new_second_vel_y_o(got.pair.v2y),
    .collided_o(got.hit),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  longint unsigned diam_model = 64'd65536;
  pair_t   pending_q[$];
  result_t resolved_q[$];
  pair_t   held;
  int      gap_cnt = 0;
  int      stall_cnt = 0;
  bit      idle_on = 1'b1;
  int      mismatches = 0;
  int      n_sent = 0, n_checked = 0, n_hits = 0, n_phases = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint c, longint unsigned dlen);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (mag << FRAC_BITS) / dlen;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t resolve_pair(pair_t a);
    result_t r;
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy, dm;
    longint ux, uy, dot, pr, ddx, ddy, h, sx, sy;
    longint unsigned d2, dlen;
    p1x = a.p1x; p1y = a.p1y; v1x = a.v1x; v1y = a.v1y;
    p2x = a.p2x; p2y = a.p2y; v2x = a.v2x; v2y = a.v2y;
    dx = p2x - p1x;
    dy = p2y - p1y;
    dm = longint'(diam_model);
    r.hit = 1'b0;
    if (dx >= -dm && dx <= dm && dy >= -dm && dy <= dm && (dx != 0 || dy != 0)) begin
      d2 = longint'(dx * dx) + longint'(dy * dy);
      dlen = int_sqrt(d2);
      ux = unit_part(dx, dlen);
      uy = unit_part(dy, dlen);
      if (d2 < diam_model * diam_model) begin
        dot = (v2x - v1x) * ux + (v2y - v1y) * uy;
        pr = dot >>> FRAC_BITS;
        ddx = (ux * pr) >>> FRAC_BITS;
        ddy = (uy * pr) >>> FRAC_BITS;
        v1x += ddx; v1y += ddy;
        v2x -= ddx; v2y -= ddy;
        r.hit = 1'b1;
      end
      if (dlen <= diam_model) begin
        h = longint'((diam_model - dlen) >> 1);
        sx = (ux * h) >>> FRAC_BITS;
        sy = (uy * h) >>> FRAC_BITS;
        p1x -= sx; p1y -= sy;
        p2x += sx; p2y += sy;
      end
    end
    r.pair.p1x = p1x[31:0]; r.pair.p1y = p1y[31:0];
    r.pair.v1x = v1x[31:0]; r.pair.v1y = v1y[31:0];
    r.pair.p2x = p2x[31:0]; r.pair.p2y = p2y[31:0];
    r.pair.v2x = v2x[31:0]; r.pair.v2y = v2y[31:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (!idle_on || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        resolved_q.push_back(resolve_pair(held));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          held = pending_q.pop_front();
          pair_drv <= held;
          in_valid_i <= 1'b1;
          gap_cnt = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (got.hit) n_hits++;
        if (resolved_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", got);
        end else begin
          want = resolved_q.pop_front();
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d\n  expected %p\n  actual   %p", mismatches, want, got);
          end
        end
      end
      out_ready_i <= (pick_gap() == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (pending_q.size() == 0 && resolved_q.size() == 0 && !in_valid_i))
      stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIM) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIM);
      $display("** ball_pair_elastic_collision: FAILED **");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

  task automatic write_diameter(logic [30:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= DIAM_ADDR; pwdata <= {1'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    diam_model = value;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || resolved_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic pair_t make_pair(bit near, bit small_vel);
    pair_t a;
    longint unsigned span;
    logic [31:0] offx, offy;
    a.p1x = $urandom; a.p1y = $urandom;
    if (near) begin
      span = (diam_model * 5) / 4 + 1;
      if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
      offx = $urandom_range(0, int'(span));
      offy = $urandom_range(0, int'(span));
      if ($urandom_range(0, 1)) offx = -offx;
      if ($urandom_range(0, 1)) offy = -offy;
      a.p2x = a.p1x + offx; a.p2y = a.p1y + offy;
    end else begin
      a.p2x = $urandom; a.p2y = $urandom;
    end
    if (small_vel) begin
      a.v1x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      a.v1y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      a.v2x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      a.v2y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    end else begin
      a.v1x = $urandom; a.v1y = $urandom; a.v2x = $urandom; a.v2y = $urandom;
    end
    return a;
  endfunction

  task automatic add_directed();
    pair_t a;
    logic [31:0] mn, mx;
    mn = 32'h8000_0000; mx = 32'h7FFF_FFFF;
    a = '{32'h10000, 32'h20000, 32'h100, 32'hFFFFFF00, 32'h10000, 32'h20000, 32'h5, 32'h7};
    pending_q.push_back(a);                                   // coincident centres
    a = '{0, 0, 32'h10000, 0, 32'h30000, 0, 32'hFFFF0000, 0};
    pending_q.push_back(a);                                   // far apart
    a = '{0, 0, 32'h10000, 0, 32'h10000, 0, 32'hFFFF0000, 0};
    pending_q.push_back(a);                                   // touching exactly
    a = '{0, 0, 32'h10000, 0, 32'h8000, 0, 32'hFFFF0000, 0};
    pending_q.push_back(a);                                   // head-on overlap
    a = '{0, 0, 32'h10000, 32'h4000, 32'h6000, 32'h7000, 0, 32'hFFFF8000};
    pending_q.push_back(a);                                   // oblique overlap
    a = '{0, 0, 0, 0, 1, 0, 0, 0};
    pending_q.push_back(a);                                   // minimal separation
    a = '{mx, mx, mn, mx, mx - 32'h4000, mx, mx, mn};
    pending_q.push_back(a);                                   // wrap at extremes
    a = '{mn, mn, mx, mn, mn + 32'h4000, mn + 32'h100, mn, mx};
    pending_q.push_back(a);
    a = '{mn, 0, 0, 0, mx, 0, 0, 0};
    pending_q.push_back(a);                                   // offset wraps past 32 bits
    a = '{mx, mn, mx, mx, mn, mx, mn, mn};
    pending_q.push_back(a);
    a = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0};
    pending_q.push_back(a);
    a = '{0, 0, 0, 0, 0, 32'hFFFF8000, 0, 32'h20000};
    pending_q.push_back(a);                                   // vertical line of centres
  endtask

  initial begin
    logic [30:0] diam_set[5];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    diam_set[0] = 31'h10000;
    diam_set[1] = 31'd1;
    diam_set[2] = 31'h7FFF_FFFF;
    diam_set[3] = 31'h30000;
    diam_set[4] = $urandom_range(2, 32'h00FF_FFFF);
    for (int ph = 0; ph < 5; ph++) begin
      write_diameter(diam_set[ph]);
      n_phases++;
      if (ph == 0 || ph == 2) add_directed();
      idle_on = (ph != 3);
      for (int i = 0; i < 255; i++)
        pending_q.push_back(make_pair($urandom_range(0, 99) < 80, $urandom_range(0, 1)));
      drain();
    end
    $display("covered %0d pairs over %0d diameter settings, %0d collisions flagged",
             n_sent, n_phases, n_hits);
    $display("checked %0d results, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && resolved_q.size() == 0)
      $display("** ball_pair_elastic_collision: PASSED **");
    else
      $display("** ball_pair_elastic_collision: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
design/bpec_pkg.sv
design/bpec_sqrt.sv
design/bpec_div.sv
design/ball_pair_elastic_collision.sv
sim/tb_top.sv
